FILE: rtl/core/keyed_table_oldest_replacement_unit_macros.svh
// Assertion macros used by the keyed table front end
`ifndef KEYED_TABLE_OLDEST_REPLACEMENT_UNIT_MACROS_SVH
`define KEYED_TABLE_OLDEST_REPLACEMENT_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define KTOR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ktor assertion failed");

// next-cycle implication, sampled on clk_i, off during reset
`define KTOR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ktor assertion failed");

`endif

FILE: rtl/core/ktor_pkg.sv
// Types and constants for the keyed record table
`timescale 1ns / 1ps
package ktor_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 16;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned COUNT_W         = 5;
  localparam int unsigned SLOT_W          = 4;

  typedef struct packed {
    logic [15:0] device_id;
    logic [31:0] last_seen;
    logic [31:0] record_payload;
  } item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] entry_count;
    logic               matched;
    logic [SLOT_W-1:0]  slot;
    logic               evicted;
  } result_t;

endpackage

FILE: rtl/core/ktor_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data
`timescale 1ns / 1ps
module ktor_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/ktor_fifo.sv
// Small command queue between the classifier and the write-back stage
`timescale 1ns / 1ps
module ktor_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] buf_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign do_push = push_i && (cnt_q != CNT_W'(DEPTH));
  assign do_pop  = pop_i && (cnt_q != '0);

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wptr_q + 1'b1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_d = CNT_W'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = CNT_W'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wptr_q] <= wdata_i;
    end
  end

  assign rdata_o = buf_q[rptr_q];
  assign empty_o = (cnt_q == '0);

endmodule

FILE: rtl/core/ktor_front.sv
// Front end: takes a record, scans the table and classifies hit, append or evict
`timescale 1ns / 1ps
`include "keyed_table_oldest_replacement_unit_macros.svh"
module ktor_front #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               start,
  output logic                                               busy,
  input  ktor_pkg::item_t                                    item_i,
  input  logic                                               fifo_empty_i,
  output logic                                               push_o,
  output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)
                + $bits(ktor_pkg::item_t) + $bits(ktor_pkg::result_t) - 1:0] cmd_o,
  output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] raddr_o,
  input  ktor_pkg::item_t                                    rdata_i
);

  import ktor_pkg::*;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WAIT = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_PUSH = 2'd3;

  logic [1:0]       state_q, state_d;
  item_t            item_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] rd_idx_q, rd_idx_d;
  logic             rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0] cmp_idx_q;
  logic             hit_q, hit_d;
  logic [IDX_W-1:0] tgt_q, tgt_d;
  logic [IDX_W-1:0] old_idx_q, old_idx_d;
  logic [31:0]      old_time_q, old_time_d;
  logic             key_eq;
  logic             room;
  logic [IDX_W-1:0] slot;
  logic [CNT_W-1:0] cnt_new;
  result_t          res;

  assign key_eq = (rdata_i.device_id == item_q.device_id);
  assign room   = (count_q < CNT_W'(TABLE_DEPTH));

  always_comb begin
    res     = '0;
    slot    = tgt_q;
    cnt_new = count_q;
    if (hit_q) begin
      res.matched = 1'b1;
    end else if (!room) begin
      slot        = old_idx_q;
      res.evicted = 1'b1;
    end else begin
      slot    = count_q[IDX_W-1:0];
      cnt_new = CNT_W'(count_q + 1'b1);
    end
    res.entry_count = COUNT_W'(cnt_new);
    res.slot        = SLOT_W'(slot);
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    rd_idx_d   = rd_idx_q;
    rd_vld_d   = 1'b0;
    hit_d      = hit_q;
    tgt_d      = tgt_q;
    old_idx_d  = old_idx_q;
    old_time_d = old_time_q;
    push_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (fifo_empty_i) begin
          state_d  = ST_SCAN;
          rd_idx_d = '0;
          hit_d    = 1'b0;
        end
      end
      ST_SCAN: begin
        if (rd_idx_q < count_q) begin
          rd_vld_d = 1'b1;
          rd_idx_d = CNT_W'(rd_idx_q + 1'b1);
        end
        if (rd_vld_q) begin
          if (key_eq && !hit_q) begin
            hit_d = 1'b1;
            tgt_d = cmp_idx_q;
          end
          if (cmp_idx_q == '0) begin
            old_idx_d  = '0;
            old_time_d = rdata_i.last_seen;
          end else if (!key_eq && (rdata_i.last_seen < old_time_q)) begin
            old_idx_d  = cmp_idx_q;
            old_time_d = rdata_i.last_seen;
          end
        end else if (rd_idx_q >= count_q) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        push_o  = 1'b1;
        count_d = cnt_new;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) begin
      item_q <= item_i;
    end
    rd_idx_q   <= rd_idx_d;
    cmp_idx_q  <= rd_idx_q[IDX_W-1:0];
    hit_q      <= hit_d;
    tgt_q      <= tgt_d;
    old_idx_q  <= old_idx_d;
    old_time_q <= old_time_d;
  end

  assign busy    = (state_q != ST_IDLE);
  assign raddr_o = rd_idx_q[IDX_W-1:0];
  assign cmd_o   = {slot, item_q, res};

  `KTOR_ASSERT_IMP(a_count_max, 1'b1, count_q <= CNT_W'(TABLE_DEPTH))
  `KTOR_ASSERT_IMP(a_push_empty, push_o, fifo_empty_i)
  `KTOR_ASSERT_IMP(a_evict_full, push_o && res.evicted, !room && !hit_q)
  `KTOR_ASSERT_NXT(a_push_idle, push_o, !busy)

endmodule

FILE: rtl/core/ktor_back.sv
// Back end: writes a classified record into the table and strobes its result
`timescale 1ns / 1ps
module ktor_back #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               fifo_empty_i,
  input  logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)
                + $bits(ktor_pkg::item_t) + $bits(ktor_pkg::result_t) - 1:0] cmd_i,
  output logic                                               pop_o,
  output logic                                               we_o,
  output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] waddr_o,
  output ktor_pkg::item_t                                    wdata_o,
  output logic                                               done_o,
  output ktor_pkg::result_t                                  result_o
);

  import ktor_pkg::*;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [IDX_W-1:0] cmd_slot;
  item_t            cmd_item;
  result_t          cmd_res;
  logic             done_q;
  result_t          res_q;

  assign {cmd_slot, cmd_item, cmd_res} = cmd_i;

  assign pop_o   = !fifo_empty_i;
  assign we_o    = !fifo_empty_i;
  assign waddr_o = cmd_slot;
  assign wdata_o = cmd_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= !fifo_empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!fifo_empty_i) begin
      res_q <= cmd_res;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

FILE: rtl/core/keyed_table_oldest_replacement_unit.sv
// Top level of the keyed record table with oldest-timestamp replacement
// Each record scans the n filled entries (n = fill count), one table entry per cycle read
//   from the RAM; start is accepted only while idle; the scan waits for an empty queue.
// done is registered in the back end when it pops the record's command from the queue.
// Results cannot be stalled; done is high for exactly one cycle per record.
// Reset clears the fill count and control state only; no clearing pass runs.
`timescale 1ns / 1ps
module keyed_table_oldest_replacement_unit #(
  parameter int unsigned TABLE_DEPTH = ktor_pkg::TABLE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ktor_pkg::item_t   item_i,
  output logic              done_o,
  output ktor_pkg::result_t result_o
);

  import ktor_pkg::*;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CMD_W = IDX_W + $bits(item_t) + $bits(result_t);

  logic             fifo_empty;
  logic             push;
  logic             pop;
  logic [CMD_W-1:0] cmd_in;
  logic [CMD_W-1:0] cmd_out;
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] waddr;
  logic             we;
  item_t            rdata;
  item_t            wdata;

  ktor_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .fifo_empty_i(fifo_empty),
    .push_o      (push),
    .cmd_o       (cmd_in),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  ktor_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(cmd_in),
    .pop_i  (pop),
    .rdata_o(cmd_out),
    .empty_o(fifo_empty)
  );

  ktor_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_empty_i(fifo_empty),
    .cmd_i       (cmd_out),
    .pop_o       (pop),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  ktor_ram #(
    .WIDTH($bits(item_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the keyed record table with oldest-timestamp replacement
module tb_top;
  import ktor_pkg::*;

  localparam int unsigned DEPTH        = TABLE_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = DEPTH + 14;
  localparam int unsigned POOL_SIZE    = 24;

  logic    clk_i = 1'b0;
  logic    rst_ni;
  logic    start;
  logic    busy;
  item_t   item_i;
  logic    done_o;
  result_t result_o;

  logic [15:0] held_ids    [DEPTH];
  logic [31:0] held_stamps [DEPTH];
  int unsigned held_count = 0;
  result_t     pending_results [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_pct = 0;
  logic [15:0] id_pool [POOL_SIZE];

  keyed_table_oldest_replacement_unit #(
    .TABLE_DEPTH(DEPTH)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // lookup, append or replace the oldest; returns the expected result beat
  function automatic result_t apply_record(item_t rec);
    result_t     res;
    int unsigned i;
    int unsigned target;
    int unsigned oldest;
    logic        hit;
    res    = '0;
    target = 0;
    oldest = 0;
    hit    = 1'b0;
    for (i = 0; i < held_count; i++) begin
      if (held_ids[i] == rec.device_id) begin
        if (!hit) begin
          hit    = 1'b1;
          target = i;
        end
      end else if (held_stamps[i] < held_stamps[oldest]) begin
        oldest = i;
      end
    end
    if (!hit) begin
      if (held_count >= DEPTH) begin
        target      = oldest;
        res.evicted = 1'b1;
      end else begin
        target     = held_count;
        held_count = held_count + 1;
      end
    end
    held_ids[target]    = rec.device_id;
    held_stamps[target] = rec.last_seen;
    res.entry_count     = COUNT_W'(held_count);
    res.matched         = hit;
    res.slot            = SLOT_W'(target);
    return res;
  endfunction

  task automatic send_record(input item_t rec);
    start  <= 1'b1;
    item_i <= rec;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_results.push_back(apply_record(rec));
  endtask

  task automatic sender_gap();
    int unsigned gap;
    gap = 0;
    if ($urandom_range(99) < idle_pct) gap = $urandom_range(1, 24);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic directed_beat(input logic [15:0] id, input logic [31:0] stamp,
                               input logic [31:0] data);
    item_t rec;
    rec.device_id      = id;
    rec.last_seen      = stamp;
    rec.record_payload = data;
    send_record(rec);
    sender_gap();
  endtask

  // fill from empty, hits below and at full, tie for oldest, repeated eviction
  task automatic test_directed_records();
    int unsigned i;
    logic [31:0] stamp;
    idle_pct = 30;
    for (i = 0; i < DEPTH; i++) begin
      if (i == 0) stamp = 32'hFFFF_FFFF;
      else if (i == 3 || i == 9) stamp = 32'd5;
      else stamp = 32'(100 + i);
      if (i == 0) directed_beat(16'h0000, stamp, 32'h0000_0000);
      else if (i == DEPTH - 1) directed_beat(16'hFFFF, stamp, 32'hFFFF_FFFF);
      else directed_beat(16'(i), stamp, $urandom());
      if (i == 1) directed_beat(16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    end
    directed_beat(16'h0005, 32'd300, 32'hA5A5_5A5A);
    directed_beat(16'h1234, 32'd200, 32'h0000_0001);
    directed_beat(16'h1235, 32'd200, 32'h8000_0000);
    directed_beat(16'h1236, 32'd200, 32'h0000_0002);
    directed_beat(16'h1237, 32'h0000_0000, 32'h0000_0003);
    directed_beat(16'h1238, 32'd201, 32'h0000_0004);
    directed_beat(16'hFFFF, 32'h0000_0000, 32'h0000_0005);
    hold_until_drained();
  endtask

  task automatic test_random_records(input int unsigned pct, input int unsigned beats);
    item_t       rec;
    int unsigned k;
    int unsigned j;
    idle_pct = pct;
    for (j = 0; j < POOL_SIZE; j++) id_pool[j] = 16'($urandom());
    for (k = 0; k < beats; k++) begin
      case ($urandom_range(9))
        0: rec.device_id = 16'($urandom());
        1: rec.device_id = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        default: rec.device_id = id_pool[$urandom_range(POOL_SIZE - 1)];
      endcase
      case ($urandom_range(9))
        0, 1, 2: rec.last_seen = 32'($urandom_range(7));
        3: rec.last_seen = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        default: rec.last_seen = $urandom();
      endcase
      rec.record_payload = $urandom();
      send_record(rec);
      if (k % 97 == 96 || k == beats - 1) hold_until_drained();
      else sender_gap();
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("tb_top: unexpected result count %0d matched %0d slot %0d evicted %0d",
                   result_o.entry_count, result_o.matched, result_o.slot,
                   result_o.evicted);
      end else begin
        want = pending_results.pop_front();
        if (result_o.entry_count !== want.entry_count || result_o.matched !== want.matched ||
            result_o.slot !== want.slot || result_o.evicted !== want.evicted) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("tb_top: mismatch exp/act count %0d/%0d matched %0d/%0d slot %0d/%0d evicted %0d/%0d",
                     want.entry_count, result_o.entry_count, want.matched, result_o.matched,
                     want.slot, result_o.slot, want.evicted, result_o.evicted);
        end
      end
    end
  end

  initial begin
    rst_ni <= 1'b0;
    start  <= 1'b0;
    item_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_records();
    test_random_records(30, 560);
    test_random_records(56, 560);
    test_random_records(0, 560);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
